### hdl/lru_pkg.sv
// lru_pkg: shared types and constants for the lru block replacement policy
// no dependencies; used by the interfaces, the cells and the top level
`default_nettype none

package lru_pkg;

    localparam int NUM_BLOCKS_DEF = 16;
    localparam int IDX_W          = 4;   // block_index field width
    localparam int VICT_W         = 4;   // victim_block field width

    typedef enum logic [1:0] {
        CMD_TOUCH  = 2'd0,
        CMD_VICTIM = 2'd1,
        CMD_INVAL  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // per-cycle control broadcast to every order cell
    typedef struct packed {
        logic touch;   // touch of an in-range block
        logic evict;   // head of the order moves to the tail
        logic push;    // append a freshly claimed block
        logic clear;   // invalidate all
    } t_cell_ctl;

endpackage

`default_nettype wire

### hdl/lru_in_if.sv
// lru_in_if: command channel of the lru replacement policy
// depends on lru_pkg for the field widths
`default_nettype none

interface lru_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               cmd;
    logic [lru_pkg::IDX_W-1:0] block_index;

    modport source (output valid, output cmd, output block_index, input ready);
    modport sink   (input valid, input cmd, input block_index, output ready);
endinterface

`default_nettype wire

### hdl/lru_out_if.sv
// lru_out_if: victim result channel of the lru replacement policy
// depends on lru_pkg for the field widths
`default_nettype none

interface lru_out_if;
    logic                      valid;
    logic                      ready;
    logic [lru_pkg::VICT_W-1:0] victim_block;
    logic                      was_free;

    modport source (output valid, output victim_block, output was_free, input ready);
    modport sink   (input valid, input victim_block, input was_free, output ready);
endinterface

`default_nettype wire

### hdl/lru_ocell.sv
// lru_ocell: one slot of the recency order (block number and occupied flag)
// depends on lru_pkg; chained head to tail inside lru_block_replacement
`default_nettype none

module lru_ocell #(
    parameter int BW = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  lru_pkg::t_cell_ctl   i_ctl,
    input  wire [BW-1:0]         i_idx,
    input  wire [BW-1:0]         i_mv_blk,
    input  wire [BW-1:0]         i_push_blk,
    input  wire                  i_match,
    input  wire                  i_prev_occ,
    input  wire                  i_next_occ,
    input  wire [BW-1:0]         i_next_blk,
    output logic                 o_match,
    output logic                 o_occ,
    output logic [BW-1:0]        o_blk
);
    import lru_pkg::*;

    logic          r_occ;
    logic [BW-1:0] r_blk;
    logic          n_occ;
    logic [BW-1:0] n_blk;
    logic          hit;
    logic          shifting;

    assign hit      = i_ctl.touch && r_occ && (r_blk == i_idx);
    assign shifting = (i_match || hit) && r_occ;
    assign o_match  = i_match || hit;
    assign o_occ    = r_occ;
    assign o_blk    = r_blk;

    always_comb begin
        n_occ = r_occ;
        n_blk = r_blk;
        if (i_ctl.clear) begin
            n_occ = 1'b0;
        end else if (shifting) begin
            // tail slot takes the moving block, others pull from the neighbor
            n_blk = i_next_occ ? i_next_blk : i_mv_blk;
        end else if (i_ctl.push && !r_occ && i_prev_occ) begin
            n_occ = 1'b1;
            n_blk = i_push_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
        r_blk <= n_blk;
    end

endmodule

`default_nettype wire

### hdl/lru_vcell.sv
// lru_vcell: valid bit of one block with lowest-free claim chaining
// depends on lru_pkg; chained from block 0 upward in lru_block_replacement
`default_nettype none

module lru_vcell (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_claim_en,
    input  wire  i_clear,
    input  wire  i_free,
    output logic o_free,
    output logic o_claim
);
    import lru_pkg::*;

    logic r_valid;
    logic n_valid;

    assign o_claim = i_claim_en && !r_valid && !i_free;
    assign o_free  = i_free || !r_valid;

    always_comb begin
        n_valid = r_valid;
        if (i_clear) begin
            n_valid = 1'b0;
        end else if (o_claim) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

### hdl/lru_block_replacement.sv
// lru_block_replacement: fully associative lru replacement over NUM_BLOCKS blocks
// result: a victim result is registered into the output register on acceptance
// throughput: one transaction per cycle while the result channel is not stalled; the row of order
//   cells updates in the accepting cycle, its critical path is the match chain rippling through NUM_BLOCKS cells
// reset: valid bits, slot occupancy and the output valid flag clear; slot contents are not reset
// depends on lru_pkg, lru_in_if, lru_out_if, lru_ocell, lru_vcell
`default_nettype none

module lru_block_replacement #(
    parameter int NUM_BLOCKS = lru_pkg::NUM_BLOCKS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    lru_in_if.sink     i_req,
    lru_out_if.source  o_rsp
);
    import lru_pkg::*;

    localparam int BW = $clog2(NUM_BLOCKS);
    localparam int IW = (BW > IDX_W) ? BW : IDX_W;

    // transaction handshake
    logic acc;
    logic in_range;
    logic [IW-1:0] idx_w;
    logic [BW-1:0] idx_b;

    // order cell row: index 0 is the least recently used slot
    t_cell_ctl          ctl;
    logic [NUM_BLOCKS:0] match_c;
    logic [NUM_BLOCKS-1:0] occ;
    logic [BW-1:0]       blk [NUM_BLOCKS];
    logic [BW-1:0]       mv_blk;
    logic [BW-1:0]       free_blk;

    // valid bit row, free flag ripples from block 0 upward
    logic [NUM_BLOCKS:0]   free_c;
    logic [NUM_BLOCKS-1:0] claim;
    logic                  any_free;
    logic                  is_victim;

    // output register
    logic              r_vld;
    logic [VICT_W-1:0] r_victim;
    logic              r_free;
    logic              n_vld;
    logic [VICT_W-1:0] n_victim;
    logic              n_free;

    assign i_req.ready = !r_vld || o_rsp.ready;
    assign acc         = i_req.valid && i_req.ready;
    assign is_victim   = acc && (t_cmd'(i_req.cmd) == CMD_VICTIM);

    assign idx_w    = IW'(i_req.block_index);
    assign idx_b    = idx_w[BW-1:0];
    assign in_range = (32'(i_req.block_index) < 32'(NUM_BLOCKS));

    // a touched block is valid exactly when it sits in an occupied slot
    assign any_free  = free_c[NUM_BLOCKS];
    assign ctl.touch = acc && (t_cmd'(i_req.cmd) == CMD_TOUCH) && in_range;
    assign ctl.evict = is_victim && !any_free;
    assign ctl.push  = is_victim && any_free;
    assign ctl.clear = acc && (t_cmd'(i_req.cmd) == CMD_INVAL);

    // eviction starts the shift at the head
    assign match_c[0] = ctl.evict;
    assign free_c[0]  = 1'b0;
    assign mv_blk     = ctl.evict ? blk[0] : idx_b;

    genvar g;
    generate
        for (g = 0; g < NUM_BLOCKS; g++) begin : g_row
            logic          prev_occ;
            logic          next_occ;
            logic [BW-1:0] next_blk;

            if (g == 0) begin : g_head
                assign prev_occ = 1'b1;
            end else begin : g_mid
                assign prev_occ = occ[g-1];
            end

            if (g == NUM_BLOCKS - 1) begin : g_tail
                assign next_occ = 1'b0;
                assign next_blk = blk[g];
            end else begin : g_body
                assign next_occ = occ[g+1];
                assign next_blk = blk[g+1];
            end

            lru_ocell #(
                .BW (BW)
            ) u_ocell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_idx      (idx_b),
                .i_mv_blk   (mv_blk),
                .i_push_blk (free_blk),
                .i_match    (match_c[g]),
                .i_prev_occ (prev_occ),
                .i_next_occ (next_occ),
                .i_next_blk (next_blk),
                .o_match    (match_c[g+1]),
                .o_occ      (occ[g]),
                .o_blk      (blk[g])
            );

            lru_vcell u_vcell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_claim_en (is_victim),
                .i_clear    (ctl.clear),
                .i_free     (free_c[g]),
                .o_free     (free_c[g+1]),
                .o_claim    (claim[g])
            );
        end
    endgenerate

    // encode the one-hot claim of the lowest free block
    always_comb begin
        free_blk = '0;
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            if (claim[i]) begin
                free_blk = free_blk | BW'(i);
            end
        end
    end

    // result register, refilled while the previous result is taken
    always_comb begin
        n_vld    = r_vld;
        n_victim = r_victim;
        n_free   = r_free;
        if (is_victim) begin
            n_vld = 1'b1;
            if (any_free) begin
                n_victim = VICT_W'(free_blk);
                n_free   = 1'b1;
            end else begin
                // empty order with every block valid cannot occur; report the head slot's block, else block 0
                n_victim = occ[0] ? VICT_W'(blk[0]) : '0;
                n_free   = 1'b0;
            end
        end else if (o_rsp.ready) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_victim <= n_victim;
        r_free   <= n_free;
    end

    assign o_rsp.valid        = r_vld;
    assign o_rsp.victim_block = r_victim;
    assign o_rsp.was_free     = r_free;

endmodule

`default_nettype wire
